[rtl/core/bop_pkg.sv]
// ============================================================================
// bop_pkg
// Shared types and constants for the binomial option pricer core.
// ============================================================================
`default_nettype none

package bop_pkg;

    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

    localparam logic [31:0] SPOT_RST = 32'd6553600;
    localparam logic [31:0] UP_RST   = 32'h4000_0000;
    localparam logic [30:0] DOWN_RST = 31'h4000_0000;
    localparam logic [30:0] PROB_RST = 31'h2000_0000;
    localparam logic [30:0] DISC_RST = 31'h4000_0000;
    localparam logic [8:0]  STEP_RST = 9'd1;

    localparam logic [2:0] REG_SPOT = 3'd0;
    localparam logic [2:0] REG_UP   = 3'd1;
    localparam logic [2:0] REG_DOWN = 3'd2;
    localparam logic [2:0] REG_PROB = 3'd3;
    localparam logic [2:0] REG_DISC = 3'd4;
    localparam logic [2:0] REG_STEP = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_U_W0, ST_U_MUL, ST_U_WR,
        ST_L_RD, ST_L_M1, ST_L_M2, ST_L_DP,
        ST_R_LD, ST_R_LD2, ST_R_RD, ST_R_M1, ST_R_M2, ST_R_M3, ST_R_WR,
        ST_F_RD, ST_F_WAIT, ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        MUL_U, MUL_LEAF, MUL_DD, MUL_P, MUL_Q, MUL_DISC
    } mul_sel_t;

    typedef enum logic [1:0] {
        WR_CUR, WR_UCH, WR_LEAF, WR_ROLL
    } wr_src_t;

    typedef enum logic [1:0] {
        RD_J, RD_J1, RD_ZERO
    } rd_src_t;

    typedef struct packed {
        logic     start;
        logic     wr_en;
        wr_src_t  wr_src;
        logic     rd_en;
        rd_src_t  rd_src;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     j_inc;
        logic     j_dec;
        logic     j_clr;
        logic     i_load;
        logic     i_dec;
        logic     dpow_ld;
        logic     lo_ld_mem;
        logic     lo_ld_hi;
        logic     hi_ld;
        logic     acc_ld;
        logic     out_ld;
    } cmd_t;

    typedef struct packed {
        logic j_eq_n;
        logic j_zero;
        logic n_zero;
        logic last_node;
        logic i_one;
    } status_t;

    // (a*b + 2^29) >> 30, 34 bits kept for the saturation check
    function automatic logic [33:0] rnd_q30(input logic [63:0] prod);
        logic [63:0] s;
        s = prod + HALF_Q30;
        return s[63:30];
    endfunction

endpackage

`default_nettype wire

[rtl/core/bop_ram.sv]
// ============================================================================
// bop_ram
// Generic RAM, one write port and one read port, registered read data.
// ============================================================================
`default_nettype none

module bop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/bop_ctrl.sv]
// ============================================================================
// bop_ctrl
// Sequencer: leaf build, payoff, roll-back and result hand-off.
// ============================================================================
`default_nettype none

module bop_ctrl
    import bop_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        cmd.wr_src  = WR_CUR;
        cmd.rd_src  = RD_J;
        cmd.mul_sel = MUL_U;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_U_W0;
                end
            end
            ST_U_W0:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_CUR;
                state_next = sts.n_zero ? ST_L_RD : ST_U_MUL;
            end
            ST_U_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_U;
                cmd.j_inc   = 1'b1;
                state_next  = ST_U_WR;
            end
            ST_U_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_UCH;
                state_next = sts.j_eq_n ? ST_L_RD : ST_U_MUL;
            end
            ST_L_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_J;
                state_next = ST_L_M1;
            end
            ST_L_M1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LEAF;
                state_next  = ST_L_M2;
            end
            ST_L_M2:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_src  = WR_LEAF;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DD;
                state_next  = ST_L_DP;
            end
            ST_L_DP:
            begin
                cmd.dpow_ld = 1'b1;
                if (sts.j_zero)
                begin
                    cmd.i_load = 1'b1;
                    state_next = sts.n_zero ? ST_F_RD : ST_R_LD;
                end
                else
                begin
                    cmd.j_dec  = 1'b1;
                    state_next = ST_L_RD;
                end
            end
            ST_R_LD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_ZERO;
                state_next = ST_R_LD2;
            end
            ST_R_LD2:
            begin
                cmd.lo_ld_mem = 1'b1;
                state_next    = ST_R_RD;
            end
            ST_R_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_J1;
                state_next = ST_R_M1;
            end
            ST_R_M1:
            begin
                cmd.hi_ld   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = ST_R_M2;
            end
            ST_R_M2:
            begin
                cmd.acc_ld  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Q;
                state_next  = ST_R_M3;
            end
            ST_R_M3:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DISC;
                cmd.lo_ld_hi = 1'b1;
                state_next   = ST_R_WR;
            end
            ST_R_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_ROLL;
                if (sts.last_node)
                begin
                    if (sts.i_one)
                    begin
                        state_next = ST_F_RD;
                    end
                    else
                    begin
                        cmd.i_dec  = 1'b1;
                        cmd.j_clr  = 1'b1;
                        state_next = ST_R_LD;
                    end
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_R_RD;
                end
            end
            ST_F_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_ZERO;
                state_next = ST_F_WAIT;
            end
            ST_F_WAIT:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    cmd.out_ld  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> cmd.start)
        else $error("accepted beat did not start a request");

    a_out_ld_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |=> m_tvalid)
        else $error("result load did not raise valid");

    a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && m_tvalid && !m_tready) |=> (state_reg == ST_FIN))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[rtl/core/bop_dp.sv]
// ============================================================================
// bop_dp
// Datapath: shared Q2.30 multiplier, lattice buffer, indices and result.
// ============================================================================
`default_nettype none

module bop_dp
    import bop_pkg::*;
#(
    parameter int MAX_STEPS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output status_t          sts,
    input  wire logic [31:0] strike_price,
    input  wire logic        is_call_option,
    input  wire logic [31:0] spot_price,
    input  wire logic [31:0] up_factor,
    input  wire logic [30:0] down_factor,
    input  wire logic [30:0] prob_up,
    input  wire logic [30:0] step_discount,
    input  wire logic [8:0]  step_count,
    output logic      [31:0] option_price,
    output logic             overflowed
);

    localparam int AW = $clog2(MAX_STEPS + 1);
    localparam int CW = (AW > 9) ? AW + 1 : 10;
    localparam logic [CW-1:0] LIM = CW'(MAX_STEPS);

    logic [AW-1:0] j_reg, i_reg, n_reg;
    logic [31:0]   strike_reg, cur_reg, dpow_reg, lo_reg, hi_reg;
    logic          call_reg, sat_reg;
    logic [63:0]   prod_reg, acc_reg;
    logic [31:0]   out_price_reg;
    logic          out_ovf_reg;

    logic [CW-1:0] sc_ext;
    logic [AW-1:0] n_lim;
    logic [30:0]   d_c, p_c, q_c, disc_c;
    logic [33:0]   r_prod;
    logic [31:0]   r_sat, s_leaf, payoff, w_roll;
    logic [33:0]   w_full;
    logic [63:0]   sum_roll;
    logic [31:0]   op_a, op_b;
    logic [31:0]   rdata, wdata;
    logic [AW-1:0] raddr;

    assign sc_ext = CW'(step_count);
    assign n_lim  = (sc_ext > LIM) ? LIM[AW-1:0] : sc_ext[AW-1:0];

    assign d_c    = (down_factor   > ONE_Q30[30:0]) ? ONE_Q30[30:0] : down_factor;
    assign p_c    = (prob_up       > ONE_Q30[30:0]) ? ONE_Q30[30:0] : prob_up;
    assign disc_c = (step_discount > ONE_Q30[30:0]) ? ONE_Q30[30:0] : step_discount;
    assign q_c    = ONE_Q30[30:0] - p_c;

    assign r_prod   = rnd_q30(prod_reg);
    assign r_sat    = (r_prod[33:32] != 2'b00) ? 32'hFFFF_FFFF : r_prod[31:0];
    assign s_leaf   = r_prod[31:0];
    assign sum_roll = acc_reg + prod_reg;
    assign w_full   = rnd_q30(sum_roll);
    assign w_roll   = w_full[31:0];

    always_comb
    begin
        if (call_reg)
        begin
            payoff = (s_leaf > strike_reg) ? s_leaf - strike_reg : 32'd0;
        end
        else
        begin
            payoff = (strike_reg > s_leaf) ? strike_reg - s_leaf : 32'd0;
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_U:    begin op_a = cur_reg;  op_b = up_factor;          end
            MUL_LEAF: begin op_a = rdata;    op_b = dpow_reg;           end
            MUL_DD:   begin op_a = dpow_reg; op_b = {1'b0, d_c};        end
            MUL_P:    begin op_a = rdata;    op_b = {1'b0, p_c};        end
            MUL_Q:    begin op_a = lo_reg;   op_b = {1'b0, q_c};        end
            MUL_DISC: begin op_a = w_roll;   op_b = {1'b0, disc_c};     end
            default:  begin op_a = cur_reg;  op_b = up_factor;          end
        endcase
    end

    always_comb
    begin
        case (cmd.wr_src)
            WR_CUR:  wdata = cur_reg;
            WR_UCH:  wdata = r_sat;
            WR_LEAF: wdata = payoff;
            WR_ROLL: wdata = r_prod[31:0];
            default: wdata = cur_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_src)
            RD_J:    raddr = j_reg;
            RD_J1:   raddr = j_reg + AW'(1);
            RD_ZERO: raddr = '0;
            default: raddr = j_reg;
        endcase
    end

    bop_ram #(
        .WIDTH (32),
        .DEPTH (MAX_STEPS + 1)
    ) u_lattice (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (j_reg),
        .wr_data (wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (raddr),
        .rd_data (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg <= '0;
            i_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                j_reg <= '0;
                n_reg <= n_lim;
            end
            else if (cmd.j_clr)
            begin
                j_reg <= '0;
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + AW'(1);
            end
            else if (cmd.j_dec)
            begin
                j_reg <= j_reg - AW'(1);
            end
            if (cmd.i_load)
            begin
                i_reg <= n_reg;
            end
            else if (cmd.i_dec)
            begin
                i_reg <= i_reg - AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            strike_reg <= strike_price;
            call_reg   <= is_call_option;
            cur_reg    <= spot_price;
            sat_reg    <= 1'b0;
            dpow_reg   <= ONE_Q30;
        end
        if (cmd.wr_en && cmd.wr_src == WR_UCH)
        begin
            cur_reg <= r_sat;
            if (r_prod[33:32] != 2'b00)
            begin
                sat_reg <= 1'b1;
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.dpow_ld)
        begin
            dpow_reg <= r_prod[31:0];
        end
        if (cmd.acc_ld)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.hi_ld)
        begin
            hi_reg <= rdata;
        end
        if (cmd.lo_ld_mem)
        begin
            lo_reg <= rdata;
        end
        else if (cmd.lo_ld_hi)
        begin
            lo_reg <= hi_reg;
        end
        if (cmd.out_ld)
        begin
            out_price_reg <= rdata;
            out_ovf_reg   <= sat_reg;
        end
    end

    assign option_price = out_price_reg;
    assign overflowed   = out_ovf_reg;

    assign sts.j_eq_n    = (j_reg == n_reg);
    assign sts.j_zero    = (j_reg == '0);
    assign sts.n_zero    = (n_reg == '0);
    assign sts.last_node = ((j_reg + AW'(1)) == i_reg);
    assign sts.i_one     = (i_reg == AW'(1));

    a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        j_reg <= n_reg)
        else $error("lattice index beyond step count");

    a_roll_index: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_src == WR_ROLL) |-> (j_reg < i_reg))
        else $error("roll-back write outside active row");

    a_n_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= AW'(MAX_STEPS))
        else $error("step count above limit");

endmodule

`default_nettype wire

[rtl/core/binomial_option_pricer_core.sv]
// ============================================================================
// binomial_option_pricer_core
// CRR binomial European option pricer, Q16.16 prices, Q2.30 factors.
// ============================================================================
// channel | dir | tdata                 | tuser
// s_axis  | in  | [31:0] strike_price   | [0] is_call_option
// m_axis  | out | [31:0] option_price   | [0] overflowed
// apb     | in  | 6 regs at 4*i         | -
//
// One request at a time through one shared 32x32 multiplier and a
// lattice buffer of MAX_STEPS+1 words with one write and one read port.
// Reset is asynchronous; the buffer needs no clearing.
// A stalled result holds in the output register; a finished request then
// waits for it to drain before accepting the next.
// ============================================================================
`default_nettype none

module binomial_option_pricer_core
    import bop_pkg::*;
#(
    parameter int MAX_STEPS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] strike_price
    input  wire logic [0:0]  s_axis_tuser,   // [0] is_call_option
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] option_price
    output logic      [0:0]  m_axis_tuser,   // [0] overflowed
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [31:0] spot_reg, up_reg;
    logic [30:0] down_reg, prob_reg, disc_reg;
    logic [8:0]  step_reg;
    logic [2:0]  ridx;
    logic        wr_stb;
    cmd_t        cmd;
    status_t     sts;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr_stb = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spot_reg <= SPOT_RST;
            up_reg   <= UP_RST;
            down_reg <= DOWN_RST;
            prob_reg <= PROB_RST;
            disc_reg <= DISC_RST;
            step_reg <= STEP_RST;
        end
        else if (wr_stb)
        begin
            case (ridx)
                REG_SPOT: spot_reg <= pwdata;
                REG_UP:   up_reg   <= pwdata;
                REG_DOWN: down_reg <= pwdata[30:0];
                REG_PROB: prob_reg <= pwdata[30:0];
                REG_DISC: disc_reg <= pwdata[30:0];
                REG_STEP: step_reg <= pwdata[8:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_SPOT: prdata = spot_reg;
            REG_UP:   prdata = up_reg;
            REG_DOWN: prdata = {1'b0, down_reg};
            REG_PROB: prdata = {1'b0, prob_reg};
            REG_DISC: prdata = {1'b0, disc_reg};
            REG_STEP: prdata = {23'd0, step_reg};
            default:  prdata = 32'd0;
        endcase
    end

    bop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bop_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .strike_price   (s_axis_tdata),
        .is_call_option (s_axis_tuser[0]),
        .spot_price     (spot_reg),
        .up_factor      (up_reg),
        .down_factor    (down_reg),
        .prob_up        (prob_reg),
        .step_discount  (disc_reg),
        .step_count     (step_reg),
        .option_price   (m_axis_tdata),
        .overflowed     (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives strike requests into the binomial option pricer under several
// lattice settings and checks each root price and overflow flag against
// a fixed-point lattice computed alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import bop_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATTICE_MAX = 256;
    localparam int STALL_LIMIT = 1000000;

    class price_board;
        logic [31:0] spot, up;
        logic [30:0] down, prob, disc;
        logic [8:0]  steps;
        logic [31:0] want_price[$];
        logic        want_ovf[$];
        int          errors;

        function new();
            spot = SPOT_RST; up = UP_RST; down = DOWN_RST;
            prob = PROB_RST; disc = DISC_RST; steps = STEP_RST;
            errors = 0;
        endfunction

        function logic [31:0] qmul(logic [31:0] a, logic [31:0] b, ref bit sat);
            logic [63:0] r;
            r = ({32'd0, a} * {32'd0, b} + 64'h2000_0000) >> 30;
            if (r > 64'hFFFF_FFFF)
            begin
                sat = 1'b1;
                return 32'hFFFF_FFFF;
            end
            return r[31:0];
        endfunction

        function logic [31:0] unit(logic [30:0] x);
            return (x > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, x};
        endfunction

        function void note_request(logic [31:0] strike, logic is_call);
            logic [31:0] node[LATTICE_MAX+1];
            logic [31:0] d, p, q, dc, dpow, s, w;
            logic [63:0] t;
            bit sat, junk;
            int n;
            sat = 0; junk = 0;
            n = (steps > LATTICE_MAX) ? LATTICE_MAX : int'(steps);
            d = unit(down); p = unit(prob); q = ONE_Q30 - p; dc = unit(disc);
            dpow = ONE_Q30;
            node[0] = spot;
            for (int j = 1; j <= n; j++)
                node[j] = qmul(node[j-1], up, sat);
            for (int j = n; j >= 0; j--)
            begin
                s = qmul(node[j], dpow, junk);
                dpow = qmul(dpow, d, junk);
                if (is_call)
                    node[j] = (s > strike) ? s - strike : 32'd0;
                else
                    node[j] = (strike > s) ? strike - s : 32'd0;
            end
            for (int i = n; i > 0; i--)
                for (int j = 0; j < i; j++)
                begin
                    t = {32'd0, p} * {32'd0, node[j+1]}
                      + {32'd0, q} * {32'd0, node[j]};
                    t = (t + 64'h2000_0000) >> 30;
                    w = t[31:0];
                    node[j] = qmul(w, dc, junk);
                end
            want_price = {want_price, node[0]};
            want_ovf = {want_ovf, sat};
        endfunction

        function void check_result(logic [31:0] price, logic ovf);
            if (want_price.size() == 0)
            begin
                $error("unexpected result beat: option_price %h", price);
                errors++;
                return;
            end
            if (price !== want_price[0])
            begin
                $error("option_price expected %h actual %h", want_price[0], price);
                errors++;
            end
            if (ovf !== want_ovf[0])
            begin
                $error("overflowed expected %b actual %b", want_ovf[0], ovf);
                errors++;
            end
            void'(want_price.pop_front());
            void'(want_ovf.pop_front());
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    price_board board = new();
    bit quiet = 1'b0;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    binomial_option_pricer_core uut (.*);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("binomial_option_pricer_core verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_SPOT: board.spot  = val;
            REG_UP:   board.up    = val;
            REG_DOWN: board.down  = val[30:0];
            REG_PROB: board.prob  = val[30:0];
            REG_DISC: board.disc  = val[30:0];
            REG_STEP: board.steps = val[8:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_request(logic [31:0] strike, logic is_call);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 19) @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= strike;
        s_axis_tuser <= is_call;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_request(strike, is_call);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (board.want_price.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apply_setting(logic [31:0] s, logic [31:0] u, logic [31:0] d,
                                 logic [31:0] p, logic [31:0] dc, logic [31:0] n);
        write_reg(REG_SPOT, s);
        write_reg(REG_UP, u);
        write_reg(REG_DOWN, d);
        write_reg(REG_PROB, p);
        write_reg(REG_DISC, dc);
        write_reg(REG_STEP, n);
    endtask

    task automatic random_batch(int count, int max_n);
        logic [31:0] strike;
        for (int k = 0; k < count; k++)
        begin
            if (k % 8 == 0)
            begin
                drain();
                apply_setting(
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF),
                    32'h4000_0000 + $urandom_range(32'h0200_0000),
                    ($urandom_range(9) == 0) ? $urandom
                        : 32'h3E00_0000 + $urandom_range(32'h0200_0000),
                    ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h4000_0000),
                    ($urandom_range(9) == 0) ? $urandom
                        : 32'h3F00_0000 + $urandom_range(32'h0100_0000),
                    $urandom_range(max_n));
            end
            strike = ($urandom_range(3) == 0) ? $urandom
                   : board.spot + $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
            send_request(strike, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, field extremes
        send_request(32'd0, 1'b1);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'd6553600, 1'b1);
        send_request(32'd6553600, 1'b0);
        drain();
        // zero steps: payoff at spot
        apply_setting(32'h0010_0000, 32'h4000_0000, 32'h4000_0000, 32'h2000_0000,
                      32'h4000_0000, 32'd0);
        send_request(32'h0008_0000, 1'b1);
        send_request(32'h0018_0000, 1'b0);
        drain();
        // u-chain saturation, factors above one clamped
        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'd8);
        send_request(32'h0000_0001, 1'b1);
        send_request(32'hFFFF_FFFF, 1'b0);
        drain();
        // up factor below one, zero factors
        apply_setting(32'h0064_0000, 32'h2000_0000, 32'd0, 32'd0, 32'd0, 32'd3);
        send_request(32'h0032_0000, 1'b0);
        send_request(32'h0001_0000, 1'b1);
        drain();
        // step count above the limit and the largest lattice
        apply_setting(32'h0064_0000, 32'h4080_0000, 32'h3F80_0000, 32'h2000_0000,
                      32'h3FF0_0000, 32'h1FF);
        send_request(32'h0064_0000, 1'b1);
        drain();
        write_reg(REG_STEP, 32'd256);
        send_request(32'h0060_0000, 1'b0);
        drain();

        quiet = 1'b1;
        random_batch(16, 6);
        quiet = 1'b0;
        random_batch(84, 12);
        drain();

        if (board.errors == 0)
            $display("binomial_option_pricer_core verification clean");
        else
            $display("binomial_option_pricer_core verification failed");
        $finish;
    end
endmodule

`default_nettype wire
